// File: design/rgaf_pkg.sv
// ----------------------------------------------------------------------------
// rgaf_pkg: shared types and constants
// Command and result word layouts, state codes, and action, fill mode and register index constants.
// ----------------------------------------------------------------------------
package rgaf_pkg;

	localparam int CW = 8;

	typedef struct packed {
		logic        action;
		logic [7:0]  left;
		logic [7:0]  top;
		logic [7:0]  right;
		logic [7:0]  bottom;
		logic [1:0]  fill_mode;
		logic [7:0]  level;
		logic [23:0] color_a;
		logic [23:0] color_b;
	} cmd_t;

	typedef struct packed {
		logic [23:0] read_color;
		logic        status;
	} res_t;

	localparam logic ACT_FILL = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [1:0] MODE_HGRAD = 2'd1;
	localparam logic [1:0] MODE_VGRAD = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_PIX   = 10'b0000000010,
		ST_DIV   = 10'b0000000100,
		ST_GRAD  = 10'b0000001000,
		ST_RD    = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_BLEND = 10'b0001000000,
		ST_WR    = 10'b0010000000,
		ST_RDOUT = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

endpackage

// File: design/rgaf_cmd_if.sv
// ----------------------------------------------------------------------------
// rgaf_cmd_if: command channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface rgaf_cmd_if;
	import rgaf_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/rgaf_res_if.sv
// ----------------------------------------------------------------------------
// rgaf_res_if: result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface rgaf_res_if;
	import rgaf_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/rect_gradient_alpha_fill_top.sv
// ----------------------------------------------------------------------------
// rect_gradient_alpha_fill_top: gradient rectangle fill with alpha blend
// A fill walks its rectangle row by row, one pixel at a time. An accepted
// command enters from the idle state, and its result waits in the output
// stage until it is taken. A pixel outside the image is skipped. A pixel
// inside the image takes these steps for a solid fill: address, store read,
// one blend step per colour channel and the store write. A gradient adds a
// multiply, a 16-step restoring divide and a ramp step per channel, because
// one shared multiplier and a 16-step restoring divider compute each colour
// channel in turn. A read passes address, store read and output register
// before its result word is presented. An empty fill presents it in the cycle after it is accepted. One
// result word per command; no command is taken until the result is taken.
// The frame store is not cleared by reset; it holds no defined data until written.
module rect_gradient_alpha_fill_top #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	rgaf_cmd_if.sink   cmd,
	rgaf_res_if.source res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import rgaf_pkg::*;

	localparam int STRIDE = (MAX_WIDTH + 3) / 4 * 4;
	localparam int DEPTH  = STRIDE * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = 16;
	localparam logic [PW-1:0] MW = PW'(MAX_WIDTH);
	localparam logic [PW-1:0] MH = PW'(MAX_HEIGHT);

	state_t state_q;
	cmd_t   cmd_q;
	logic [7:0] wreg_q, hreg_q;
	logic [7:0] x_q, y_q;
	logic [1:0] ch_q;
	logic       status_q;
	logic [AW-1:0] addr_q;
	logic [23:0] col_q, out_q;
	logic [3:0]  dcnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic        neg_q;

	logic [PW-1:0] w_eff, h_eff, stride, xe, ye;
	logic          outside;
	logic          more_x, more_y;
	logic          ram_we;
	logic [23:0]   ram_rdata;
	logic [7:0]    span, idx, c1, c2, nc, oc;
	logic [7:0]    diff_abs;
	logic          diff_neg;
	logic [16:0]   rem_sh;
	logic [7:0]    qv;
	logic [16:0]   mac;
	logic [7:0]    bv;

	always_comb begin
		w_eff = (wreg_q == 8'd0) ? PW'(1) : ((PW'(wreg_q) > MW) ? MW : PW'(wreg_q));
		h_eff = (hreg_q == 8'd0) ? PW'(1) : ((PW'(hreg_q) > MH) ? MH : PW'(hreg_q));
		stride = (w_eff + PW'(3)) & ~PW'(3);
		xe = PW'(x_q);
		ye = PW'(y_q);
		outside = (xe >= w_eff) || (ye >= h_eff);
		more_x = (x_q + 8'd1) < cmd_q.right;
		more_y = (y_q + 8'd1) < cmd_q.bottom;
	end

	// shared unit operands
	always_comb begin
		c1 = cmd_q.color_a[ch_q*8 +: 8];
		c2 = cmd_q.color_b[ch_q*8 +: 8];
		nc = col_q[ch_q*8 +: 8];
		oc = (cmd_q.level == 8'hFF) ? 8'd0 : ram_rdata[ch_q*8 +: 8];
		diff_neg = c2 < c1;
		diff_abs = diff_neg ? (c1 - c2) : (c2 - c1);
		if (cmd_q.fill_mode == MODE_HGRAD) begin
			span = cmd_q.right - cmd_q.left;
			idx  = x_q - cmd_q.left;
		end else begin
			span = cmd_q.bottom - cmd_q.top;
			idx  = y_q - cmd_q.top;
		end
		rem_sh = {rem_q, quo_q[15]};
		qv = neg_q ? (c1 - quo_q[7:0]) : (c1 + quo_q[7:0]);
		mac = 17'(cmd_q.level) * 17'(nc) + 17'(8'hFF - cmd_q.level) * 17'(oc);
		bv = 8'((mac + 17'd1 + (mac >> 8)) >> 8);
	end

	assign ram_we = (state_q == ST_WR);

	rgaf_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (addr_q),
		.wdata (col_q),
		.rdata (ram_rdata)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_OUT);
	assign res.data  = '{read_color: out_q, status: status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wreg_q <= 8'd128;
			hreg_q <= 8'd128;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) wreg_q <= cfg_data;
			else if (cfg_index == REG_HEIGHT) hreg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			ch_q     <= '0;
			status_q <= 1'b0;
			addr_q   <= '0;
			col_q    <= '0;
			out_q    <= '0;
			dcnt_q   <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						cmd_q    <= cmd.data;
						x_q      <= cmd.data.left;
						y_q      <= cmd.data.top;
						status_q <= 1'b0;
						out_q    <= '0;
						if (cmd.data.action == ACT_READ) begin
							state_q <= ST_PIX;
						end else if (cmd.data.right > cmd.data.left &&
								cmd.data.bottom > cmd.data.top) begin
							state_q <= ST_PIX;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_PIX: begin
					addr_q <= AW'(stride * (h_eff - PW'(1) - ye) + xe);
					ch_q   <= 2'd0;
					if (outside) begin
						status_q <= 1'b1;
						if (cmd_q.action == ACT_READ) state_q <= ST_OUT;
						else if (more_x) x_q <= x_q + 8'd1;
						else if (more_y) begin
							x_q <= cmd_q.left;
							y_q <= y_q + 8'd1;
						end else state_q <= ST_OUT;
					end else if (cmd_q.action == ACT_READ) begin
						state_q <= ST_RD;
					end else if (cmd_q.fill_mode == MODE_HGRAD ||
							cmd_q.fill_mode == MODE_VGRAD) begin
						state_q <= ST_MUL;
					end else begin
						col_q   <= cmd_q.color_a;
						state_q <= ST_RD;
					end
				end
				ST_MUL: begin
					// |i*(c2-c1)| then restoring divide by span
					quo_q   <= 16'(idx) * 16'(diff_abs);
					neg_q   <= diff_neg;
					rem_q   <= '0;
					dcnt_q  <= 4'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rem_sh >= 17'(span)) begin
						rem_q <= 16'(rem_sh - 17'(span));
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= rem_sh[15:0];
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd15) state_q <= ST_GRAD;
				end
				ST_GRAD: begin
					col_q[ch_q*8 +: 8] <= qv;
					if (ch_q == 2'd2) begin
						ch_q    <= 2'd0;
						state_q <= ST_RD;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_RD: begin
					state_q <= (cmd_q.action == ACT_READ) ? ST_RDOUT : ST_BLEND;
				end
				ST_RDOUT: begin
					out_q   <= ram_rdata;
					state_q <= ST_OUT;
				end
				ST_BLEND: begin
					col_q[ch_q*8 +: 8] <= bv;
					if (ch_q == 2'd2) begin
						ch_q    <= 2'd0;
						state_q <= ST_WR;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_WR: begin
					if (more_x) begin
						x_q     <= x_q + 8'd1;
						state_q <= ST_PIX;
					end else if (more_y) begin
						x_q     <= cmd_q.left;
						y_q     <= y_q + 8'd1;
						state_q <= ST_PIX;
					end else state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/rgaf_ram.sv
// ----------------------------------------------------------------------------
// rgaf_ram: generic single-port RAM
// One read per cycle, plus a write when we is set, at one address; registered read data.
// ----------------------------------------------------------------------------
module rgaf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: gradient rectangle fill with alpha blend
// Drives fill and read commands into the block, keeps a shadow frame store
// that applies the same fill, gradient and blend arithmetic, and compares
// every result word with the oldest predicted one. The image size registers
// are changed between phases, once no result is outstanding.
// ----------------------------------------------------------------------------
module testbench;
	import rgaf_pkg::*;

	localparam int FRAME_STRIDE = 128;
	localparam int FRAME_DEPTH  = FRAME_STRIDE * 128;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	rgaf_cmd_if cmd_ch ();
	rgaf_res_if res_ch ();

	rect_gradient_alpha_fill_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [23:0] shadow_frame [FRAME_DEPTH];
	logic [7:0]  shadow_width;
	logic [7:0]  shadow_height;
	res_t        expected_words [$];
	int          errors;
	bit          calm;
	int          ready_hold;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int eff_width();
		if (shadow_width == 8'd0) return 1;
		if (shadow_width > 8'd128) return 128;
		return int'(shadow_width);
	endfunction

	function automatic int eff_height();
		if (shadow_height == 8'd0) return 1;
		if (shadow_height > 8'd128) return 128;
		return int'(shadow_height);
	endfunction

	function automatic int frame_addr(int x, int y);
		int w;
		int h;
		w = eff_width();
		h = eff_height();
		if (x >= w || y >= h) return -1;
		return ((w + 3) / 4 * 4) * (h - 1 - y) + x;
	endfunction

	function automatic logic [23:0] ramp_color(logic [23:0] ca, logic [23:0] cb, int i,
			int span);
		logic [23:0] r;
		int c1;
		int c2;
		int v;
		for (int sh = 0; sh < 24; sh += 8) begin
			c1 = int'(ca[sh +: 8]);
			c2 = int'(cb[sh +: 8]);
			v = c1 + (i * (c2 - c1)) / span;
			r[sh +: 8] = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [23:0] mix_color(logic [23:0] nw, logic [23:0] old, int lvl);
		logic [23:0] r;
		int v;
		for (int sh = 0; sh < 24; sh += 8) begin
			v = (lvl * int'(nw[sh +: 8]) + (255 - lvl) * int'(old[sh +: 8])) / 255;
			r[sh +: 8] = v[7:0];
		end
		return r;
	endfunction

	function automatic res_t paint_or_sample(cmd_t c);
		res_t r;
		int a;
		logic [23:0] col;
		r = '0;
		if (c.action == ACT_READ) begin
			a = frame_addr(int'(c.left), int'(c.top));
			if (a < 0) r.status = 1'b1;
			else r.read_color = shadow_frame[a];
		end else if (c.right > c.left && c.bottom > c.top) begin
			for (int y = int'(c.top); y < int'(c.bottom); y++) begin
				for (int x = int'(c.left); x < int'(c.right); x++) begin
					a = frame_addr(x, y);
					if (a < 0) begin
						r.status = 1'b1;
						continue;
					end
					if (c.fill_mode == MODE_HGRAD)
						col = ramp_color(c.color_a, c.color_b, x - int'(c.left),
							int'(c.right) - int'(c.left));
					else if (c.fill_mode == MODE_VGRAD)
						col = ramp_color(c.color_a, c.color_b, y - int'(c.top),
							int'(c.bottom) - int'(c.top));
					else
						col = c.color_a;
					shadow_frame[a] = mix_color(col, shadow_frame[a], int'(c.level));
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int n;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			ready_hold <= 0;
		end else if (res_ch.valid && res_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result read_color=%h status=%b", $time,
					res_ch.data.read_color, res_ch.data.status);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (res_ch.data.read_color !== want.read_color) begin
					$display("%0t: read_color expected %h actual %h", $time,
						want.read_color, res_ch.data.read_color);
					errors++;
				end
				if (res_ch.data.status !== want.status) begin
					$display("%0t: status expected %b actual %b", $time,
						want.status, res_ch.data.status);
					errors++;
				end
			end
			n = calm ? 0 : $urandom_range(0, 4);
			ready_hold <= n;
			res_ch.ready <= (n == 0);
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			res_ch.ready <= (ready_hold == 1);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic send_word(cmd_t c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
		expected_words.push_back(paint_or_sample(c));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_WIDTH) shadow_width = val;
		else if (idx == REG_HEIGHT) shadow_height = val;
	endtask

	task automatic set_geometry(logic [7:0] w, logic [7:0] h);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	function automatic cmd_t make_cmd(logic act, int l, int t, int r, int b, int m, int lvl,
			logic [23:0] ca, logic [23:0] cb);
		cmd_t c;
		c.action = act;
		c.left = l[7:0];
		c.top = t[7:0];
		c.right = r[7:0];
		c.bottom = b[7:0];
		c.fill_mode = m[1:0];
		c.level = lvl[7:0];
		c.color_a = ca;
		c.color_b = cb;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int w;
		int h;
		int pick;
		w = eff_width();
		h = eff_height();
		c.fill_mode = 2'($urandom_range(0, 3));
		c.level = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
		c.color_a = 24'($urandom_range(0, 24'hFFFFFF));
		c.color_b = 24'($urandom_range(0, 24'hFFFFFF));
		c.right = 8'($urandom_range(0, 255));
		c.bottom = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			c.action = ACT_READ;
			c.left = 8'($urandom_range(0, w - 1));
			c.top = 8'($urandom_range(0, h - 1));
			if (pick < 4) begin
				c.left = 8'($urandom_range(0, 255));
				c.top = 8'($urandom_range(0, 255));
			end
		end else begin
			c.action = ACT_FILL;
			c.left = 8'($urandom_range(0, w + 1));
			c.top = 8'($urandom_range(0, h + 1));
			if (pick == 99) begin
				c.left = 8'($urandom_range(0, 255));
				c.right = 8'($urandom_range(0, 255));
				c.bottom = c.top + 8'($urandom_range(0, 2));
			end else if (pick < 34) begin
				c.right = c.left - 8'($urandom_range(0, 2));
				c.bottom = c.top + 8'($urandom_range(0, 4));
			end else begin
				c.right = c.left + 8'($urandom_range(0, 5));
				c.bottom = c.top + 8'($urandom_range(0, 5));
			end
		end
		return c;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			send_word(random_cmd());
		end
		calm = 1'b0;
	endtask

	task automatic test_prime_frame();
		send_word(make_cmd(ACT_FILL, 0, 0, 128, 128, 0, 255,
			24'($urandom_range(0, 24'hFFFFFF)), 0));
	endtask

	task automatic test_directed();
		send_word(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_READ, 127, 127, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_READ, 128, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_READ, 0, 128, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_READ, 255, 255, 255, 255, 3, 255, 24'hFFFFFF, 24'hFFFFFF));
		send_word(make_cmd(ACT_FILL, 2, 2, 6, 5, 0, 255, 24'hFFFFFF, 0));
		send_word(make_cmd(ACT_FILL, 2, 2, 6, 5, 1, 255, 24'h000000, 24'hFFFFFF));
		send_word(make_cmd(ACT_FILL, 2, 2, 6, 5, 2, 128, 24'hFF8000, 24'h00FF7F));
		send_word(make_cmd(ACT_FILL, 2, 2, 6, 5, 3, 200, 24'h123456, 24'hABCDEF));
		send_word(make_cmd(ACT_FILL, 3, 3, 5, 5, 1, 0, 24'hFFFFFF, 0));
		send_word(make_cmd(ACT_FILL, 3, 3, 5, 5, 2, 1, 24'hFFFFFF, 0));
		send_word(make_cmd(ACT_READ, 3, 4, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_FILL, 10, 10, 10, 20, 1, 255, 24'hFFFFFF, 0));
		send_word(make_cmd(ACT_FILL, 10, 10, 20, 9, 2, 255, 24'hFFFFFF, 0));
		send_word(make_cmd(ACT_FILL, 124, 125, 131, 129, 1, 255, 24'hFF00FF, 24'h00FF00));
		send_word(make_cmd(ACT_FILL, 126, 120, 128, 255, 2, 90, 24'h0000FF, 24'hFF0000));
		send_word(make_cmd(ACT_READ, 127, 126, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_FILL, 0, 126, 128, 128, 1, 255, 24'h000000, 24'hFFFFFF));
		send_word(make_cmd(ACT_READ, 127, 127, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(ACT_READ, 64, 126, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_geometry();
		set_geometry(8'd0, 8'd0);
		run_random(60);
		set_geometry(8'd1, 8'd1);
		run_random(60);
		set_geometry(8'd255, 8'd255);
		run_random(80);
		set_geometry(8'd5, 8'd3);
		run_random(80);
		set_geometry(8'd128, 8'd1);
		run_random(80);
		set_geometry(8'd1, 8'd128);
		run_random(80);
		set_geometry(8'd127, 8'd100);
		run_random(80);
		set_geometry(8'd6, 8'd7);
		run_random(80);
	endtask

	task automatic test_random_traffic();
		set_geometry(8'd128, 8'd128);
		run_random(500);
		drain();
		run_random(300);
		set_geometry(8'd33, 8'd17);
		run_random(200);
	endtask

	initial begin
		errors = 0;
		calm = 1'b0;
		shadow_width = 8'd128;
		shadow_height = 8'd128;
		foreach (shadow_frame[i]) shadow_frame[i] = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_prime_frame();
		test_directed();
		test_geometry();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
